// File: sv/aapr_pkg.sv
package aapr_pkg;

    localparam int TAB_LEN = 24;

    localparam logic signed [33:0] Q30_ONE     = 34'sd1073741824;
    localparam logic signed [33:0] Q30_HALF_PI = 34'sd1686629713;
    localparam logic signed [33:0] Q30_PI      = 34'sd3373259426;
    localparam logic signed [33:0] INV_GAIN    = 34'sd652032874;

    localparam logic signed [43:0] SAT_MAX = 44'sd2147483647;
    localparam logic signed [43:0] SAT_MIN = -44'sd2147483648;

    // offset, centre and axis travelling beside the sine/cosine work
    typedef struct packed {
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [32:0] dz;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
    } geom_t;

    typedef struct packed {
        geom_t              g;
        logic               neg;
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
    } cordic_t;

    // matrix entries in Q24, row major
    typedef struct packed {
        geom_t           g;
        logic [8:0][30:0] mq;
    } mat_t;

    function automatic logic signed [33:0] atan_q30(input logic [4:0] idx);
        logic signed [33:0] r;
        begin
            case (idx)
                5'd0:    r = 34'sh3243F6A8;
                5'd1:    r = 34'sh1DAC6705;
                5'd2:    r = 34'sh0FADBAFC;
                5'd3:    r = 34'sh07F56EA6;
                5'd4:    r = 34'sh03FEAB76;
                5'd5:    r = 34'sh01FFD55B;
                5'd6:    r = 34'sh00FFFAAA;
                5'd7:    r = 34'sh007FFF55;
                5'd8:    r = 34'sh003FFFEA;
                5'd9:    r = 34'sh001FFFFD;
                5'd10:   r = 34'sh000FFFFF;
                5'd11:   r = 34'sh0007FFFF;
                5'd12:   r = 34'sh0003FFFF;
                5'd13:   r = 34'sh0001FFFF;
                5'd14:   r = 34'sh0000FFFF;
                5'd15:   r = 34'sh00007FFF;
                5'd16:   r = 34'sh00003FFF;
                5'd17:   r = 34'sh00001FFF;
                5'd18:   r = 34'sh00000FFF;
                5'd19:   r = 34'sh000007FF;
                5'd20:   r = 34'sh000003FF;
                5'd21:   r = 34'sh000001FF;
                5'd22:   r = 34'sh000000FF;
                5'd23:   r = 34'sh0000007F;
                default: r = 34'sd0;
            endcase
            return r;
        end
    endfunction

    // round half up, floor shift
    function automatic logic signed [67:0] rnd68(input logic signed [67:0] v, input int n);
        logic signed [67:0] half;
        begin
            half = 68'sd1 <<< (n - 1);
            return (v + half) >>> n;
        end
    endfunction

endpackage

// File: sv/aapr_if.sv
interface aapr_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic signed [15:0] angle;

    modport source (output valid, point_x, point_y, point_z, center_x, center_y, center_z,
                    axis_x, axis_y, axis_z, angle, input ready);
    modport sink (input valid, point_x, point_y, point_z, center_x, center_y, center_z,
                  axis_x, axis_y, axis_z, angle, output ready);
endinterface

interface aapr_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] rotated_x;
    logic signed [31:0] rotated_y;
    logic signed [31:0] rotated_z;

    modport source (output valid, rotated_x, rotated_y, rotated_z, input ready);
    modport sink (input valid, rotated_x, rotated_y, rotated_z, output ready);
endinterface

// File: sv/aapr_cordic_cell.sv
module aapr_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic             clk,
    input  logic             en,
    input  aapr_pkg::cordic_t din,
    output aapr_pkg::cordic_t dout
);
    import aapr_pkg::*;

    cordic_t            dout_reg;
    cordic_t            dout_next;
    logic signed [33:0] dxs;
    logic signed [33:0] dys;
    logic signed [33:0] at;

    assign dxs = din.y >>> STAGE;
    assign dys = din.x >>> STAGE;
    assign at  = atan_q30(5'(STAGE));

    always_comb
    begin
        dout_next = din;
        if (!din.z[33])
        begin
            dout_next.x = din.x - dxs;
            dout_next.y = din.y + dys;
            dout_next.z = din.z - at;
        end
        else
        begin
            dout_next.x = din.x + dxs;
            dout_next.y = din.y - dys;
            dout_next.z = din.z + at;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            dout_reg <= dout_next;
    end

    assign dout = dout_reg;

endmodule

// File: sv/aapr_matrix.sv
module aapr_matrix (
    input  logic              clk,
    input  logic              en,
    input  aapr_pkg::cordic_t din,
    output aapr_pkg::mat_t    dout
);
    import aapr_pkg::*;

    geom_t              ga_reg;
    logic signed [33:0] ca_reg;
    logic signed [33:0] sa_reg;
    logic signed [34:0] ta_reg;
    logic signed [31:0] aa_reg [9];

    geom_t              gb_reg;
    logic signed [33:0] cb_reg;
    logic signed [66:0] tp_reg [9];
    logic signed [49:0] sp_reg [3];

    mat_t               dout_reg;

    logic signed [33:0] c_next;
    logic signed [33:0] s_next;
    logic signed [15:0] av [3];
    logic signed [15:0] avb [3];
    logic signed [39:0] sa [3];
    logic signed [39:0] m [9];

    assign c_next = din.neg ? -din.x : din.x;
    assign s_next = din.neg ? -din.y : din.y;
    assign av[0]  = din.g.ax;
    assign av[1]  = din.g.ay;
    assign av[2]  = din.g.az;
    assign avb[0] = ga_reg.ax;
    assign avb[1] = ga_reg.ay;
    assign avb[2] = ga_reg.az;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            sa[k] = 40'(rnd68(68'(sp_reg[k]), 14));
        for (int k = 0; k < 9; k++)
            m[k] = 40'(rnd68(68'(tp_reg[k]), 28));
        m[0] = m[0] + 40'(cb_reg);
        m[4] = m[4] + 40'(cb_reg);
        m[8] = m[8] + 40'(cb_reg);
        m[1] = m[1] - sa[2];
        m[3] = m[3] + sa[2];
        m[2] = m[2] + sa[1];
        m[6] = m[6] - sa[1];
        m[5] = m[5] - sa[0];
        m[7] = m[7] + sa[0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // cos, sin, 1 - cos and axis outer product
            ga_reg <= din.g;
            ca_reg <= c_next;
            sa_reg <= s_next;
            ta_reg <= 35'(Q30_ONE) - 35'(c_next);
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    aa_reg[3 * i + j] <= av[i] * av[j];

            gb_reg <= ga_reg;
            cb_reg <= ca_reg;
            for (int k = 0; k < 9; k++)
                tp_reg[k] <= ta_reg * aa_reg[k];
            for (int k = 0; k < 3; k++)
                sp_reg[k] <= avb[k] * sa_reg;

            dout_reg.g <= gb_reg;
            for (int k = 0; k < 9; k++)
                dout_reg.mq[k] <= 31'(rnd68(68'(m[k]), 6));
        end
    end

    assign dout = dout_reg;

endmodule

// File: sv/aapr_apply.sv
module aapr_apply (
    input  logic                clk,
    input  logic                en,
    input  aapr_pkg::mat_t      din,
    output logic signed [31:0] rx,
    output logic signed [31:0] ry,
    output logic signed [31:0] rz
);
    import aapr_pkg::*;

    logic signed [63:0] prod_reg [9];
    logic signed [31:0] ctr_reg [3];
    logic signed [31:0] res_reg [3];

    logic signed [32:0] dv [3];
    logic signed [31:0] cv [3];
    logic signed [65:0] acc [3];
    logic signed [43:0] sum [3];
    logic signed [31:0] res_next [3];

    assign dv[0] = din.g.dx;
    assign dv[1] = din.g.dy;
    assign dv[2] = din.g.dz;
    assign cv[0] = din.g.cx;
    assign cv[1] = din.g.cy;
    assign cv[2] = din.g.cz;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            acc[i] = 66'(prod_reg[3 * i]) + 66'(prod_reg[3 * i + 1])
                   + 66'(prod_reg[3 * i + 2]);
            sum[i] = 44'(rnd68(68'(acc[i]), 24)) + 44'(ctr_reg[i]);
            if (sum[i] > SAT_MAX)
                res_next[i] = 32'sh7FFFFFFF;
            else if (sum[i] < SAT_MIN)
                res_next[i] = 32'sh80000000;
            else
                res_next[i] = sum[i][31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                    prod_reg[3 * i + j] <= $signed(din.mq[3 * i + j]) * dv[j];
                ctr_reg[i] <= cv[i];
                res_reg[i] <= res_next[i];
            end
        end
    end

    assign rx = res_reg[0];
    assign ry = res_reg[1];
    assign rz = res_reg[2];

endmodule

// File: sv/axis_angle_point_rotator.sv
// channel   dir  interface    payload
// sample    in   aapr_in_if   point, centre, axis (Q2.14), angle (Q3.13)
// result    out  aapr_out_if  rotated point, Q16.16 saturated
//
// one item per cycle while no result waits; stages: input register, one
// cordic cell per stage (<= TAB_LEN), three matrix, product and sum stages
// the whole pipeline advances together and holds while a result waits
// rst_n clears only the valid bits, payload registers are not reset
module axis_angle_point_rotator #(
    parameter int SINCOS_STAGES = 16
) (
    input logic       clk,
    input logic       rst_n,
    aapr_in_if.sink   sample,
    aapr_out_if.source result
);
    import aapr_pkg::*;

    localparam int NST = (SINCOS_STAGES > TAB_LEN) ? TAB_LEN : SINCOS_STAGES;
    localparam int LAT = NST + 6;

    logic [LAT-1:0]     vld_reg;
    logic               en;
    cordic_t            chain [NST + 1];
    cordic_t            in_reg;
    cordic_t            in_next;
    mat_t               mat;
    logic signed [33:0] z0;

    assign en           = !vld_reg[LAT-1] || result.ready;
    assign sample.ready = en;
    assign result.valid = vld_reg[LAT-1];

    always_comb
    begin
        in_next.g.dx = {sample.point_x[31], sample.point_x}
                     - {sample.center_x[31], sample.center_x};
        in_next.g.dy = {sample.point_y[31], sample.point_y}
                     - {sample.center_y[31], sample.center_y};
        in_next.g.dz = {sample.point_z[31], sample.point_z}
                     - {sample.center_z[31], sample.center_z};
        in_next.g.cx = sample.center_x;
        in_next.g.cy = sample.center_y;
        in_next.g.cz = sample.center_z;
        in_next.g.ax = sample.axis_x;
        in_next.g.ay = sample.axis_y;
        in_next.g.az = sample.axis_z;
        in_next.x    = INV_GAIN;
        in_next.y    = '0;
        z0 = $signed({sample.angle[15], sample.angle, 17'b0});
        // fold the angle into +-pi/2, negate cos and sin afterwards
        if (z0 > Q30_HALF_PI)
        begin
            in_next.z   = z0 - Q30_PI;
            in_next.neg = 1'b1;
        end
        else if (z0 < -Q30_HALF_PI)
        begin
            in_next.z   = z0 + Q30_PI;
            in_next.neg = 1'b1;
        end
        else
        begin
            in_next.z   = z0;
            in_next.neg = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], sample.valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
            in_reg <= in_next;
    end

    assign chain[0] = in_reg;

    for (genvar g = 0; g < NST; g++)
    begin : g_cell
        aapr_cordic_cell #(.STAGE(g)) u_cell (
            .clk  (clk),
            .en   (en),
            .din  (chain[g]),
            .dout (chain[g + 1])
        );
    end

    aapr_matrix u_matrix (
        .clk  (clk),
        .en   (en),
        .din  (chain[NST]),
        .dout (mat)
    );

    aapr_apply u_apply (
        .clk (clk),
        .en  (en),
        .din (mat),
        .rx  (result.rotated_x),
        .ry  (result.rotated_y),
        .rz  (result.rotated_z)
    );

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        en |=> vld_reg[0] == $past(sample.valid))
        else $error("input valid bit not captured");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !vld_reg[LAT-1] |-> sample.ready)
        else $error("input refused with empty output stage");

endmodule
